// ----- hdl/pda_pkg.sv -----
// Shared types, constants and the EGA preload table for the palette allocator.
package pda_pkg;

  // Default sizes
  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned PreloadEntriesDef = 16;

  // Field widths fixed by the interface
  localparam int unsigned RgbW = 24;
  localparam int unsigned IdxOutW = 8;
  localparam int unsigned ReqW = 2;

  // Request codes
  localparam logic [ReqW-1:0] REQ_PREPARE = 2'd0;
  localparam logic [ReqW-1:0] REQ_ADD_RSV = 2'd1;
  localparam logic [ReqW-1:0] REQ_MAP     = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_ALLOC,
    S_DONE
  } pda_state_e;

  // 16-color set modeled on the EGA palette
  function automatic logic [RgbW-1:0] ega_color(input logic [3:0] idx);
    logic [RgbW-1:0] c;
    unique case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h0000AB;
      4'd2:    c = 24'h00AB00;
      4'd3:    c = 24'h00ABAB;
      4'd4:    c = 24'hAB0000;
      4'd5:    c = 24'hAB00AB;
      4'd6:    c = 24'hAB5700;
      4'd7:    c = 24'hABABAB;
      4'd8:    c = 24'h575757;
      4'd9:    c = 24'h5757FF;
      4'd10:   c = 24'h57FF57;
      4'd11:   c = 24'h57FFFF;
      4'd12:   c = 24'hFF5757;
      4'd13:   c = 24'hFF57FF;
      4'd14:   c = 24'hFFFF57;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/palette_dedup_allocator_top.sv -----
// Palette allocator: color table memory, search/allocate sequencer, result register.
//
// Usage:
//  - Request channel (in_valid_i/in_ready_o) carries req_type_i and color_rgb_i.
//    Prepare resets the palette, add-reserved allocates a reserved entry, map
//    returns the highest matching unreserved entry or allocates a new one.
//  - Result channel (out_valid_o/out_ready_i) returns one result per request.
//  - Config channel (cfg_valid_i/cfg_ready_o) writes local_mode; write it only
//    while no request is outstanding.
//  - One request is processed at a time. A map request reads one table entry
//    per cycle from the color memory, searching down through the searched
//    range (up to PALETTE_ENTRIES entries) and stopping at the first match.
//  - A new request is accepted while the previous result still waits in the
//    output register; a stalled receiver holds the result and the sequencer
//    waits in its final state until the output register frees up.
//  - Reset (and prepare) clears all per-entry valid bits at once; no
//    clearing pass is needed. After reset the palette is in local mode with
//    the EGA colors preloaded.
module palette_dedup_allocator_top
  import pda_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PaletteEntriesDef,
  parameter int unsigned PRELOAD_ENTRIES = PreloadEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_local_mode_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ReqW-1:0]     req_type_i,
  input  logic [RgbW-1:0]     color_rgb_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IdxOutW-1:0]  entry_index_o,
  output logic                found_existing_o,
  output logic                full_error_o
);

  localparam int unsigned IdxW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CurW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CurW-1:0] CurTop  = CurW'(PALETTE_ENTRIES);
  localparam logic [CurW-1:0] CurLast = CurW'(PALETTE_ENTRIES - 1);
  localparam logic [CurW-1:0] CurPre  = CurW'(PRELOAD_ENTRIES);

  // Control state
  pda_state_e          state_q, state_d;
  logic [CurW-1:0]     cursor_q, cursor_d;
  logic                local_mode_q, local_mode_d;
  logic                preload_q, preload_d;
  logic                cmp_valid_q, cmp_valid_d;
  logic                out_valid_q, out_valid_d;
  logic [PALETTE_ENTRIES-1:0] entry_vld_q;

  // Payload state
  logic [ReqW-1:0]     req_q, req_d;
  logic [RgbW-1:0]     rgb_q, rgb_d;
  logic                rsv_q, rsv_d;
  logic [CurW-1:0]     cnt_q, cnt_d;
  logic [CurW-1:0]     lo_q, lo_d;
  logic [IdxW-1:0]     cmp_addr_q, cmp_addr_d;
  logic [IdxW-1:0]     res_idx_q, res_idx_d;
  logic                res_found_q, res_found_d;
  logic                res_full_q, res_full_d;
  logic [IdxW-1:0]     out_idx_q, out_idx_d;
  logic                out_found_q, out_found_d;
  logic                out_full_q, out_full_d;

  // Memory signals
  logic [RgbW:0]       mem [PALETTE_ENTRIES];
  logic [RgbW:0]       rd_data_q;
  logic                rd_vld_q;
  logic [CurW-1:0]     cnt_m1;
  logic [IdxW-1:0]     rd_addr;
  logic [IdxW-1:0]     wr_addr;
  logic                mem_we;
  logic                vld_clr;

  // Entry as seen by the compare: untouched entries read as their reset value
  logic [RgbW-1:0]     eff_rgb;
  logic                eff_rsv;
  logic                hit;

  assign cnt_m1  = cnt_q - CurW'(1);
  assign rd_addr = cnt_m1[IdxW-1:0];

  assign eff_rsv = rd_vld_q & rd_data_q[RgbW];
  always_comb begin
    if (rd_vld_q) begin
      eff_rgb = rd_data_q[RgbW-1:0];
    end else if (preload_q && (cmp_addr_q < IdxW'(PRELOAD_ENTRIES))) begin
      eff_rgb = ega_color(cmp_addr_q[3:0]);
    end else begin
      eff_rgb = '0;
    end
  end
  assign hit = cmp_valid_q && !eff_rsv && (eff_rgb == rgb_q);

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign entry_index_o    = IdxOutW'(out_idx_q);
  assign found_existing_o = out_found_q;
  assign full_error_o     = out_full_q;

  // Color memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= {rsv_q, rgb_q};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= entry_vld_q[rd_addr];
  end

  // Per-entry written flags, cleared at once by reset or prepare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
    end else if (vld_clr) begin
      entry_vld_q <= '0;
    end else if (mem_we) begin
      entry_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cursor_q     <= CurPre;
      local_mode_q <= 1'b1;
      preload_q    <= 1'b1;
      cmp_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      local_mode_q <= local_mode_d;
      preload_q    <= preload_d;
      cmp_valid_q  <= cmp_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rgb_q       <= rgb_d;
    rsv_q       <= rsv_d;
    cnt_q       <= cnt_d;
    lo_q        <= lo_d;
    cmp_addr_q  <= cmp_addr_d;
    res_idx_q   <= res_idx_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
  end

  // Cursor minus one, cut to an entry index
  function automatic logic [IdxW-1:0] cnt_sub1(input logic [CurW-1:0] v);
    logic [CurW-1:0] t;
    t = v - CurW'(1);
    return t[IdxW-1:0];
  endfunction

  // Sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    local_mode_d = local_mode_q;
    preload_d    = preload_q;
    cmp_valid_d  = cmp_valid_q;
    req_d        = req_q;
    rgb_d        = rgb_q;
    rsv_d        = rsv_q;
    cnt_d        = cnt_q;
    lo_d         = lo_q;
    cmp_addr_d   = cmp_addr_q;
    res_idx_d    = res_idx_q;
    res_found_d  = res_found_q;
    res_full_d   = res_full_q;
    out_idx_d    = out_idx_q;
    out_found_d  = out_found_q;
    out_full_d   = out_full_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    wr_addr      = cursor_q[IdxW-1:0];
    vld_clr      = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      local_mode_d = cfg_local_mode_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          rgb_d   = color_rgb_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_idx_d   = '0;
        res_found_d = 1'b0;
        res_full_d  = 1'b0;
        cmp_valid_d = 1'b0;
        case (req_q)
          REQ_PREPARE: begin
            vld_clr   = 1'b1;
            preload_d = local_mode_q;
            cursor_d  = local_mode_q ? CurPre : CurTop;
            state_d   = S_DONE;
          end
          REQ_ADD_RSV: begin
            rsv_d   = 1'b1;
            state_d = S_ALLOC;
          end
          REQ_MAP: begin
            rsv_d   = 1'b0;
            lo_d    = local_mode_q ? '0 : cursor_q;
            cnt_d   = local_mode_q ? cursor_q : CurTop;
            state_d = S_SCAN;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // Top-down search, one read issued and one compare per cycle
      S_SCAN: begin
        if (hit) begin
          res_idx_d   = cmp_addr_q;
          res_found_d = 1'b1;
          cmp_valid_d = 1'b0;
          state_d     = S_DONE;
        end else if (cnt_q != lo_q) begin
          cmp_valid_d = 1'b1;
          cmp_addr_d  = rd_addr;
          cnt_d       = cnt_m1;
        end else begin
          cmp_valid_d = 1'b0;
          state_d     = S_ALLOC;
        end
      end

      // Allocate a new entry or flag a full palette
      S_ALLOC: begin
        state_d = S_DONE;
        if (local_mode_q) begin
          if (cursor_q >= CurLast) begin
            res_full_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            wr_addr   = cursor_q[IdxW-1:0];
            res_idx_d = cursor_q[IdxW-1:0];
            cursor_d  = cursor_q + CurW'(1);
          end
        end else begin
          if (cursor_q <= CurPre) begin
            res_full_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            wr_addr   = cnt_sub1(cursor_q);
            res_idx_d = cnt_sub1(cursor_q);
            cursor_d  = cursor_q - CurW'(1);
          end
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_found_d = res_found_q;
          out_full_d  = res_full_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Checks
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_q >= CurPre) && (cursor_q <= CurTop))
    else $error("allocation cursor out of range");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("memory written during search");

  a_found_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_existing_o && full_error_o))
    else $error("result both found and full");

  a_full_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_error_o) |-> (entry_index_o == '0))
    else $error("refused allocation returned nonzero index");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

endmodule
